[rtl/core/pwra_pkg.sv]
// Shared types and constants for the power window request arbiter.
// Holds event codes, direction codes, register indexes and the queued command type.
// No dependencies.
package pwra_pkg;

  localparam int EVENT_W = 4;
  localparam int DIR_W   = 2;
  localparam int TIME_W  = 16;
  localparam int CFG_IDX_W = 1;

  // Window event codes. Codes above EV_UNLOCK act as an idle tick.
  localparam logic [EVENT_W-1:0] EV_IDLE       = 4'd0;
  localparam logic [EVENT_W-1:0] EV_LIMIT_UP   = 4'd1;
  localparam logic [EVENT_W-1:0] EV_LIMIT_DOWN = 4'd2;
  localparam logic [EVENT_W-1:0] EV_JAM        = 4'd3;
  localparam logic [EVENT_W-1:0] EV_LOCK       = 4'd4;
  localparam logic [EVENT_W-1:0] EV_PASS_UP    = 4'd5;
  localparam logic [EVENT_W-1:0] EV_PASS_DOWN  = 4'd6;
  localparam logic [EVENT_W-1:0] EV_DRV_UP     = 4'd7;
  localparam logic [EVENT_W-1:0] EV_DRV_DOWN   = 4'd8;
  localparam logic [EVENT_W-1:0] EV_AUTO_UP    = 4'd9;
  localparam logic [EVENT_W-1:0] EV_AUTO_DOWN  = 4'd10;
  localparam logic [EVENT_W-1:0] EV_UNLOCK     = 4'd11;

  // Motor direction codes.
  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_STOP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_REVERSE = 1'd1;
  localparam logic [TIME_W-1:0] JAM_STOP_RESET    = 16'd20;
  localparam logic [TIME_W-1:0] JAM_REVERSE_RESET = 16'd500;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    logic             jam;
    logic             motor_on;
    logic [DIR_W-1:0] move_direction;
  } pwra_cmd_t;

  // Step of the three-request jam sequence.
  typedef enum logic [1:0] {
    PH_STOP,
    PH_REVERSE,
    PH_OFF
  } pwra_phase_t;

endpackage

[rtl/core/power_window_request_arbiter_top.sv]
// Power window request arbiter, top level. Depends on pwra_pkg and the front, queue, back modules.
// An accepted request is registered in the queue and then in the back end's output register.
// Throughput: one request per cycle for single-result events while the queue has room and the
// motor side is ready; a jam holds the output register for its three stop/reverse/off requests.
// Reset (rst, synchronous): lock and both one-touch latches clear, the queue empties, the output
// register goes invalid and the jam times return to 20 ms and 500 ms.
module power_window_request_arbiter_top import pwra_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  // Event requests.
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [EVENT_W-1:0]   event_code,
  // Motor requests.
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 motor_on,
  output logic [DIR_W-1:0]     move_direction,
  output logic [TIME_W-1:0]    run_time,
  output logic                 last_of_run,
  // Register writes: index 0 is the jam stop time, index 1 the jam reverse time.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  // The front end updates the lock flag and latches as soon as a request is accepted, so
  // every later request sees the state its predecessors left, no matter how far the back
  // end has fallen behind. Only the classified command crosses the queue.
  pwra_cmd_t front_cmd;
  pwra_cmd_t back_cmd;
  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_not_empty;

  pwra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .event_code (event_code),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  // The queue lets the front end keep taking requests while a jam sequence drains.
  pwra_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .pop       (pop),
    .pop_data  (back_cmd),
    .full      (queue_full),
    .not_empty (queue_not_empty)
  );

  // The back end pops a command only once its final motor request is loaded into the
  // output register, which is refilled in the same cycle the downstream side takes it.
  pwra_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (back_cmd),
    .cmd_valid      (queue_not_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_on       (motor_on),
    .move_direction (move_direction),
    .run_time       (run_time),
    .last_of_run    (last_of_run)
  );

endmodule

[rtl/core/pwra_front.sv]
// Front end: accepts event codes, keeps lock and one-touch latch state,
// and classifies each event into a queued command. Depends on pwra_pkg.
module pwra_front import pwra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [EVENT_W-1:0] event_code,
  input  logic               queue_full,
  output logic               push,
  output pwra_cmd_t          cmd
);

  logic lock_engaged, lock_engaged_next;
  logic auto_up_latched, auto_up_latched_next;
  logic auto_down_latched, auto_down_latched_next;
  logic follow;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    lock_engaged_next      = lock_engaged;
    auto_up_latched_next   = auto_up_latched;
    auto_down_latched_next = auto_down_latched;
    follow                 = 1'b0;
    cmd                    = '{jam: 1'b0, motor_on: 1'b0, move_direction: DIR_NONE};
    case (event_code)
      EV_LIMIT_UP: begin
        auto_up_latched_next = 1'b0;
      end
      EV_LIMIT_DOWN: begin
        auto_down_latched_next = 1'b0;
      end
      EV_JAM: begin
        auto_up_latched_next   = 1'b0;
        auto_down_latched_next = 1'b0;
        cmd.jam                = 1'b1;
      end
      EV_LOCK: begin
        lock_engaged_next = 1'b1;
        follow            = 1'b1;
      end
      EV_UNLOCK: begin
        lock_engaged_next = 1'b0;
        follow            = 1'b1;
      end
      EV_PASS_UP, EV_PASS_DOWN: begin
        auto_up_latched_next   = 1'b0;
        auto_down_latched_next = 1'b0;
        if (!lock_engaged) begin
          cmd.motor_on       = 1'b1;
          cmd.move_direction = (event_code == EV_PASS_UP) ? DIR_UP : DIR_DOWN;
        end
      end
      EV_DRV_UP, EV_DRV_DOWN: begin
        auto_up_latched_next   = 1'b0;
        auto_down_latched_next = 1'b0;
        cmd.motor_on           = 1'b1;
        cmd.move_direction     = (event_code == EV_DRV_UP) ? DIR_UP : DIR_DOWN;
      end
      EV_AUTO_UP: begin
        auto_up_latched_next   = !auto_down_latched;
        auto_down_latched_next = 1'b0;
        follow                 = 1'b1;
      end
      EV_AUTO_DOWN: begin
        auto_down_latched_next = !auto_up_latched;
        auto_up_latched_next   = 1'b0;
        follow                 = 1'b1;
      end
      default: begin
        follow = 1'b1;
      end
    endcase

    // Events that do not pick a move themselves report the latched one-touch move.
    if (follow) begin
      if (auto_up_latched_next) begin
        auto_down_latched_next = 1'b0;
        cmd.motor_on           = 1'b1;
        cmd.move_direction     = DIR_UP;
      end else if (auto_down_latched_next) begin
        cmd.motor_on       = 1'b1;
        cmd.move_direction = DIR_DOWN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_engaged      <= 1'b0;
      auto_up_latched   <= 1'b0;
      auto_down_latched <= 1'b0;
    end else if (push) begin
      lock_engaged      <= lock_engaged_next;
      auto_up_latched   <= auto_up_latched_next;
      auto_down_latched <= auto_down_latched_next;
    end
  end

endmodule

[rtl/core/pwra_fifo.sv]
// Short command queue between the front end and the back end.
// Flip-flop storage with one write and one read port. Depends on pwra_pkg.
module pwra_fifo import pwra_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pwra_cmd_t push_data,
  input  logic      pop,
  output pwra_cmd_t pop_data,
  output logic      full,
  output logic      not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pwra_cmd_t         slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/pwra_back.sv]
// Back end: holds the jam timing registers, expands queued commands into
// motor requests and drives the output register. Depends on pwra_pkg.
module pwra_back import pwra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  pwra_cmd_t            cmd,
  input  logic                 cmd_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 motor_on,
  output logic [DIR_W-1:0]     move_direction,
  output logic [TIME_W-1:0]    run_time,
  output logic                 last_of_run
);

  logic [TIME_W-1:0] jam_stop_time;
  logic [TIME_W-1:0] jam_reverse_time;
  pwra_phase_t       phase, phase_next;
  logic              load;
  logic              motor_on_next;
  logic [DIR_W-1:0]  move_direction_next;
  logic [TIME_W-1:0] run_time_next;
  logic              last_of_run_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      jam_stop_time    <= JAM_STOP_RESET;
      jam_reverse_time <= JAM_REVERSE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_JAM_STOP:    jam_stop_time    <= cfg_data;
        CFG_JAM_REVERSE: jam_reverse_time <= cfg_data;
        default: ;
      endcase
    end
  end

  assign load = cmd_valid && (!out_valid || out_ready);

  always_comb begin
    phase_next          = phase;
    pop                 = 1'b0;
    motor_on_next       = cmd.motor_on;
    move_direction_next = cmd.move_direction;
    run_time_next       = '0;
    last_of_run_next    = 1'b1;
    if (cmd.jam) begin
      case (phase)
        PH_STOP: begin
          motor_on_next       = 1'b0;
          move_direction_next = DIR_NONE;
          run_time_next       = jam_stop_time;
          last_of_run_next    = 1'b0;
        end
        PH_REVERSE: begin
          motor_on_next       = 1'b1;
          move_direction_next = DIR_DOWN;
          run_time_next       = jam_reverse_time;
          last_of_run_next    = 1'b0;
        end
        default: begin
          motor_on_next       = 1'b0;
          move_direction_next = DIR_NONE;
        end
      endcase
    end
    if (load) begin
      if (!cmd.jam) begin
        pop = 1'b1;
      end else begin
        case (phase)
          PH_STOP:    phase_next = PH_REVERSE;
          PH_REVERSE: phase_next = PH_OFF;
          default: begin
            phase_next = PH_STOP;
            pop        = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_STOP;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      motor_on       <= motor_on_next;
      move_direction <= move_direction_next;
      run_time       <= run_time_next;
      last_of_run    <= last_of_run_next;
    end
  end

endmodule

[rtl/core/pwra_checker.sv]
// Port-level checks for the power window request arbiter.
// Depends on pwra_pkg; bound to power_window_request_arbiter_top below.
module pwra_checker import pwra_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              motor_on,
  input logic [DIR_W-1:0]  move_direction,
  input logic [TIME_W-1:0] run_time,
  input logic              last_of_run
);

  // A motor request that is not taken stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_on) && $stable(move_direction)
      && $stable(run_time) && $stable(last_of_run))
    else $error("stalled motor request changed");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("motor request valid after reset");

  // A running motor always has a direction; a stopped one has none.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_on && (move_direction == DIR_UP || move_direction == DIR_DOWN))
      || (!motor_on && move_direction == DIR_NONE))
    else $error("motor direction inconsistent with motor on");

  // Only a jam sequence gives non-final requests: the timed stop or the downward reversal.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !motor_on || move_direction == DIR_DOWN)
    else $error("non-final request is not part of a jam sequence");

  // A final request that stops the motor carries no duration.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run && !motor_on |-> run_time == '0)
    else $error("final stop request carries a duration");

endmodule

bind power_window_request_arbiter_top pwra_checker u_pwra_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .motor_on       (motor_on),
  .move_direction (move_direction),
  .run_time       (run_time),
  .last_of_run    (last_of_run)
);

[tb/power_window_request_arbiter_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for power_window_request_arbiter_top.
// Depends on pwra_pkg and the arbiter RTL; it predicts every motor request internally and checks
// each one as it leaves the block.
module power_window_request_arbiter_top_tb;
  import pwra_pkg::*;

  // This limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT = 200000;
  // Margin that wait_for_results adds after the last owed motor request is out.
  localparam int SETTLE_CYCLES = 6;

  // One motor request as it leaves the block.
  typedef struct packed {
    logic              motor_on;
    logic [DIR_W-1:0]  move_direction;
    logic [TIME_W-1:0] run_time;
    logic              last_of_run;
  } motor_req_t;

  // How the motor side accepts requests when no long hold-off is running.
  typedef enum {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } ready_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid;
  logic                 in_ready;
  logic [EVENT_W-1:0]   event_code;
  logic                 out_valid;
  logic                 out_ready;
  logic                 motor_on;
  logic [DIR_W-1:0]     move_direction;
  logic [TIME_W-1:0]    run_time;
  logic                 last_of_run;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;

  // Predicted window state and jam timing, updated as each request is accepted.
  logic              lock_engaged;
  logic              auto_up_latched;
  logic              auto_down_latched;
  logic [TIME_W-1:0] jam_stop_time;
  logic [TIME_W-1:0] jam_reverse_time;

  // Motor requests that the block still owes, oldest first.
  motor_req_t pending_motor_reqs[$];

  int fail_count  = 0;
  int cycle_count = 0;

  // Receiver control. The test side bumps hold_off_seq to ask for a hold-off of length hold_off_len;
  // the receiver process keeps its own copy of the sequence and counts the hold-off down.
  ready_style_t ready_style  = STALL_NONE;
  int           hold_off_len = 0;
  int           hold_off_seq = 0;
  int           hold_off_seen = 0;
  int           hold_left    = 0;
  int           pattern_step = 0;

  power_window_request_arbiter_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .event_code     (event_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_on       (motor_on),
    .move_direction (move_direction),
    .run_time       (run_time),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  // Run limit. A hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Motor side ready. A requested hold-off takes precedence over the normal stall style.
  always @(posedge clk) begin
    if (hold_off_seq != hold_off_seen) begin
      hold_off_seen = hold_off_seq;
      hold_left     = hold_off_len;
    end
    pattern_step = (pattern_step + 1) % 7;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (ready_style)
        STALL_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
        STALL_PATTERN: out_ready <= (pattern_step >= 2);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  // Checks each motor request against the oldest prediction. Sampling at the falling edge sees
  // exactly the values that the next rising edge will act on, so no race with the drivers.
  always @(negedge clk) begin : check_motor_req
    motor_req_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_motor_reqs.size() == 0) begin
        $error("unexpected motor request: motor_on %0d move_direction %0d run_time %0d",
               motor_on, move_direction, run_time);
        fail_count++;
      end else begin
        want = pending_motor_reqs.pop_front();
        if (motor_on !== want.motor_on) begin
          $error("motor_on: expected %0d, got %0d", want.motor_on, motor_on);
          fail_count++;
        end
        if (move_direction !== want.move_direction) begin
          $error("move_direction: expected %0d, got %0d", want.move_direction, move_direction);
          fail_count++;
        end
        if (run_time !== want.run_time) begin
          $error("run_time: expected %0d, got %0d", want.run_time, run_time);
          fail_count++;
        end
        if (last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d", want.last_of_run, last_of_run);
          fail_count++;
        end
      end
    end
  end

  function automatic void owe_motor_req(input logic on, input logic [DIR_W-1:0] dir,
                                        input logic [TIME_W-1:0] duration, input logic last);
    motor_req_t req;
    req.motor_on       = on;
    req.move_direction = dir;
    req.run_time       = duration;
    req.last_of_run    = last;
    pending_motor_reqs.push_back(req);
  endfunction

  // Applies one event to the predicted state and queues the motor requests it causes.
  // Limits, jams and manual presses answer directly; everything else follows the latches.
  function automatic void arbitrate_event(input logic [EVENT_W-1:0] code);
    logic follows_latches;
    follows_latches = 1'b1;
    case (code)
      EV_LIMIT_UP: begin
        auto_up_latched = 1'b0;
        follows_latches = 1'b0;
      end
      EV_LIMIT_DOWN: begin
        auto_down_latched = 1'b0;
        follows_latches   = 1'b0;
      end
      EV_JAM: begin
        auto_up_latched   = 1'b0;
        auto_down_latched = 1'b0;
        // Stop, reverse downward, then off. The stop carries a duration although the motor is off.
        owe_motor_req(1'b0, DIR_NONE, jam_stop_time, 1'b0);
        owe_motor_req(1'b1, DIR_DOWN, jam_reverse_time, 1'b0);
        owe_motor_req(1'b0, DIR_NONE, '0, 1'b1);
        return;
      end
      EV_LOCK:   lock_engaged = 1'b1;
      EV_UNLOCK: lock_engaged = 1'b0;
      EV_PASS_UP, EV_PASS_DOWN: begin
        auto_up_latched   = 1'b0;
        auto_down_latched = 1'b0;
        follows_latches   = 1'b0;
        if (lock_engaged) owe_motor_req(1'b0, DIR_NONE, '0, 1'b1);
        else owe_motor_req(1'b1, (code == EV_PASS_UP) ? DIR_UP : DIR_DOWN, '0, 1'b1);
      end
      EV_DRV_UP, EV_DRV_DOWN: begin
        auto_up_latched   = 1'b0;
        auto_down_latched = 1'b0;
        follows_latches   = 1'b0;
        owe_motor_req(1'b1, (code == EV_DRV_UP) ? DIR_UP : DIR_DOWN, '0, 1'b1);
      end
      // A second one-touch press against the running direction stops both.
      EV_AUTO_UP: begin
        auto_up_latched   = !auto_down_latched;
        auto_down_latched = 1'b0;
      end
      EV_AUTO_DOWN: begin
        auto_down_latched = !auto_up_latched;
        auto_up_latched   = 1'b0;
      end
      default: ;
    endcase
    if (!follows_latches) begin
      if (code == EV_LIMIT_UP || code == EV_LIMIT_DOWN) owe_motor_req(1'b0, DIR_NONE, '0, 1'b1);
    end else if (auto_up_latched) begin
      auto_down_latched = 1'b0;
      owe_motor_req(1'b1, DIR_UP, '0, 1'b1);
    end else if (auto_down_latched) begin
      owe_motor_req(1'b1, DIR_DOWN, '0, 1'b1);
    end else begin
      owe_motor_req(1'b0, DIR_NONE, '0, 1'b1);
    end
  endfunction

  // Offers one event request and returns at the edge that accepts it. Valid stays high so that
  // the next request can follow in the very next cycle; sender_gap lowers it.
  task automatic send_event(input logic [EVENT_W-1:0] code);
    in_valid   <= 1'b1;
    event_code <= code;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    arbitrate_event(code);
  endtask

  task automatic sender_gap(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pauses the sender until every owed motor request is out and the pipeline has settled.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_motor_reqs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Called only while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [TIME_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (index == CFG_JAM_STOP) jam_stop_time = value;
    else jam_reverse_time = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_jam_times(input logic [TIME_W-1:0] stop_ms,
                               input logic [TIME_W-1:0] reverse_ms);
    write_register(CFG_JAM_STOP, stop_ms);
    write_register(CFG_JAM_REVERSE, reverse_ms);
  endtask

  task automatic send_sequence(input logic [EVENT_W-1:0] codes[$]);
    foreach (codes[i]) send_event(codes[i]);
    wait_for_results();
  endtask

  // Random event mix. Jams and the one-touch keys are favored so that the latches are often set
  // when the other events arrive; the unused codes show up now and then.
  function automatic logic [EVENT_W-1:0] random_event();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return EV_JAM;
    if (pick < 12) return EVENT_W'(EV_UNLOCK + 1 + $urandom_range(0, 3));
    if (pick < 24) return EV_AUTO_UP;
    if (pick < 36) return EV_AUTO_DOWN;
    if (pick < 46) return EV_IDLE;
    return EVENT_W'($urandom_range(EV_IDLE, EV_UNLOCK));
  endfunction

  // A jam right after reset must use the reset stop and reverse times.
  task automatic test_jam_sequence();
    ready_style = STALL_NONE;
    send_event(EV_JAM);
    wait_for_results();
  endtask

  // Setting, holding, toggling and clearing the one-touch latches, including a limit that does
  // not touch the latch of the other direction.
  task automatic test_one_touch_latches();
    logic [EVENT_W-1:0] codes[$];
    codes = '{EV_AUTO_UP, EV_IDLE, EV_AUTO_UP, EV_AUTO_DOWN, EV_AUTO_DOWN, EV_LIMIT_UP,
              EV_IDLE, EV_LIMIT_DOWN, EV_AUTO_DOWN, EV_JAM};
    ready_style = STALL_PATTERN;
    send_sequence(codes);
  endtask

  // Manual presses clear the latches, the lock blocks only the passenger switch, and the lock
  // itself answers with whatever the latches hold. The unused codes behave as idle ticks.
  task automatic test_manual_and_lock();
    logic [EVENT_W-1:0] codes[$];
    codes = '{EV_AUTO_UP, EV_PASS_UP, EV_PASS_DOWN, EV_LOCK, EV_AUTO_DOWN, EV_PASS_UP,
              EV_DRV_UP, EV_DRV_DOWN, EV_UNLOCK, EV_PASS_DOWN};
    for (int c = EV_UNLOCK + 1; c < 2 ** EVENT_W; c++) codes.push_back(EVENT_W'(c));
    ready_style = STALL_RANDOM;
    send_sequence(codes);
  endtask

  // Jam timing at the extremes of both registers.
  task automatic test_jam_times();
    set_jam_times('0, '1);
    send_event(EV_JAM);
    wait_for_results();
    set_jam_times('1, '0);
    send_event(EV_JAM);
    wait_for_results();
  endtask

  // The motor side holds off for a long stretch while events keep coming, so the internal queue
  // fills and in_ready must drop. The sender then pauses until everything has drained.
  task automatic test_input_backpressure();
    ready_style  = STALL_NONE;
    hold_off_len = 80;
    hold_off_seq++;
    for (int i = 0; i < 16; i++) send_event(random_event());
    wait_for_results();
  endtask

  // Random traffic in several phases, each with its own jam timing and receiver behavior.
  // The sender works in bursts of random length; a zero gap joins two bursts into one.
  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       set_jam_times('1, '1);
        2:       set_jam_times('0, '0);
        default: set_jam_times(TIME_W'($urandom_range(0, 16'hFFFF)),
                               TIME_W'($urandom_range(0, 16'hFFFF)));
      endcase
      case (phase)
        0:       ready_style = STALL_NONE;
        1:       ready_style = STALL_PATTERN;
        default: ready_style = STALL_RANDOM;
      endcase
      sent = 0;
      while (sent < 75) begin
        burst = $urandom_range(1, 10);
        for (int k = 0; k < burst && sent < 75; k++) begin
          send_event(random_event());
          sent++;
        end
        sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
      end
      wait_for_results();
    end
  endtask

  initial begin
    in_valid          <= 1'b0;
    event_code        <= EV_IDLE;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_JAM_STOP;
    cfg_data          <= '0;
    lock_engaged      = 1'b0;
    auto_up_latched   = 1'b0;
    auto_down_latched = 1'b0;
    jam_stop_time     = JAM_STOP_RESET;
    jam_reverse_time  = JAM_REVERSE_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_jam_sequence();
    test_one_touch_latches();
    test_manual_and_lock();
    test_jam_times();
    test_input_backpressure();
    test_random_traffic();

    wait_for_results();
    if (fail_count == 0 && pending_motor_reqs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
